// ===== hdl/pmwr_pkg.sv =====
`timescale 1ns / 1ps

package pmwr_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned WARMUP_W  = 20;
    localparam int unsigned POWOFF_W  = 16;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 20;

    // Reset values of the configuration registers.
    localparam logic [WARMUP_W-1:0] WARMUP_RESET = WARMUP_W'(60000);
    localparam logic [POWOFF_W-1:0] POWOFF_RESET = POWOFF_W'(1000);
    localparam logic                SWITCH_RESET = 1'b0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_MS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_OFF_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH       = 2'd2;

    // Command codes; the unused code behaves as a plain tick.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RECAL = 2'd1,
        CMD_CLEAR = 2'd2
    } pmwr_cmd_t;

    // Kind of the last edge seen.
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_RISE = 2'd1,
        EV_FALL = 2'd2
    } pmwr_event_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       sensor_level;
    } pmwr_in_t;

    typedef struct packed {
        logic                motion;
        logic                ready_res;
        logic                recal_active;
        logic                sensor_power;
        logic                cmd_ok;
        logic [COUNT_W-1:0]  event_count;
        logic [1:0]          last_event;
        logic [TIME_W-1:0]   last_event_ms;
        logic [WARMUP_W-1:0] warmup_left_ms;
    } pmwr_out_t;

    typedef struct packed {
        logic [WARMUP_W-1:0] warmup_ms;
        logic [POWOFF_W-1:0] power_off_ms;
        logic                power_switch_present;
    } pmwr_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  clock_ms;
        logic [TIME_W-1:0]  warmup_start_ms;
        logic [TIME_W-1:0]  recal_start_ms;
        logic               recal_flag;
        logic               ready_flag;
        logic               previous_level;
        logic               motion_flag;
        logic [COUNT_W-1:0] rise_count;
        pmwr_event_t        event_kind;
        logic [TIME_W-1:0]  event_time_ms;
        logic               power_flag;
    } pmwr_state_t;

endpackage

// ===== hdl/pmwr_step.sv =====
`timescale 1ns / 1ps

// Next-state and result logic for one millisecond tick.
module pmwr_step (
    input  pmwr_pkg::pmwr_state_t state_cur,
    input  pmwr_pkg::pmwr_cfg_t   cfg,
    input  pmwr_pkg::pmwr_in_t    item,
    output pmwr_pkg::pmwr_state_t state_nxt,
    output pmwr_pkg::pmwr_out_t   result
);
    import pmwr_pkg::*;

    logic                is_recal;
    logic                recal_start;
    logic                cmd_ok;
    logic [TIME_W-1:0]   t;
    logic [TIME_W-1:0]   recal_base;
    logic [TIME_W-1:0]   recal_elapsed;
    logic                phase_on;
    logic                recal_any;
    logic [TIME_W-1:0]   warm_elapsed;
    logic [TIME_W-1:0]   left_elapsed;
    logic                rise;
    logic                fall;
    pmwr_state_t         s;

    assign t = state_cur.clock_ms;

    // Command decode: a recalibration needs a switchable supply.
    assign is_recal    = (item.cmd == CMD_RECAL);
    assign cmd_ok      = !(is_recal && !cfg.power_switch_present);
    assign recal_start = is_recal && cfg.power_switch_present && !state_cur.recal_flag;
    assign recal_any   = state_cur.recal_flag || recal_start;

    // Power-off phase test, seeing a phase that starts in this tick.
    assign recal_base    = recal_start ? t : state_cur.recal_start_ms;
    assign recal_elapsed = t - recal_base;
    assign phase_on      = recal_elapsed < {{(TIME_W-POWOFF_W){1'b0}}, cfg.power_off_ms};

    // Warm-up time and edges for the normal path.
    assign warm_elapsed = t - state_cur.warmup_start_ms;
    assign rise         = item.sensor_level && !state_cur.previous_level;
    assign fall         = !item.sensor_level && state_cur.previous_level;

    always_comb
    begin
        s          = state_cur;
        s.clock_ms = t + TIME_W'(1);
        if (item.cmd == CMD_CLEAR) begin
            s.rise_count = '0;
        end
        if (recal_start) begin
            s.power_flag     = 1'b0;
            s.recal_flag     = 1'b1;
            s.recal_start_ms = t;
            s.ready_flag     = 1'b0;
        end
        if (recal_any) begin
            // At the end of the phase the supply returns and warm-up restarts.
            if (!phase_on) begin
                s.power_flag      = 1'b1;
                s.ready_flag      = 1'b0;
                s.warmup_start_ms = t;
                s.motion_flag     = 1'b0;
                s.previous_level  = 1'b0;
                s.recal_flag      = 1'b0;
            end
        end else begin
            if (warm_elapsed >= {{(TIME_W-WARMUP_W){1'b0}}, cfg.warmup_ms}) begin
                s.ready_flag = 1'b1;
            end
            if (rise) begin
                s.rise_count    = s.rise_count + COUNT_W'(1);
                s.event_time_ms = t;
                s.event_kind    = EV_RISE;
            end
            if (fall) begin
                s.event_time_ms = t;
                s.event_kind    = EV_FALL;
            end
            s.previous_level = item.sensor_level;
            s.motion_flag    = item.sensor_level;
        end
    end

    assign state_nxt = s;

    // Remaining warm-up, taken from the updated state.
    assign left_elapsed = t - s.warmup_start_ms;

    always_comb
    begin
        result.motion        = s.motion_flag;
        result.ready_res     = s.ready_flag;
        result.recal_active  = s.recal_flag;
        result.sensor_power  = s.power_flag;
        result.cmd_ok        = cmd_ok;
        result.event_count   = s.rise_count;
        result.last_event    = s.event_kind;
        result.last_event_ms = s.event_time_ms;
        if (s.ready_flag
            || left_elapsed >= {{(TIME_W-WARMUP_W){1'b0}}, cfg.warmup_ms}) begin
            result.warmup_left_ms = '0;
        end else begin
            result.warmup_left_ms = cfg.warmup_ms - left_elapsed[WARMUP_W-1:0];
        end
    end

endmodule

// ===== hdl/pir_motion_warmup_recal_controller.sv =====
`timescale 1ns / 1ps

// PIR motion sensor controller with warm-up and power-cycle recalibration. Each input
// beat is one millisecond tick carrying the sensor sample and a command; it yields
// exactly one result beat. The block takes a tick in every clock cycle unless a held
// result stalls it: the whole update is one pass of logic from the state registers into
// the state and result registers, and a new tick is accepted whenever the result register
// is empty or being drained in the same cycle. Results appear in the cycle after their
// tick. Configuration writes are taken in any cycle (cfg_ready is always high), and are
// meant to happen only while no tick is in flight.
module pir_motion_warmup_recal_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  pmwr_pkg::pmwr_in_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output pmwr_pkg::pmwr_out_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pmwr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pmwr_pkg::CFG_DAT_W-1:0]       cfg_data
);
    import pmwr_pkg::*;

    pmwr_cfg_t   cfg_reg;
    pmwr_state_t state_reg;
    pmwr_state_t state_next;
    pmwr_out_t   out_data_reg;
    pmwr_out_t   out_data_next;
    logic        out_valid_reg;
    logic        in_fire;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.warmup_ms            <= WARMUP_RESET;
            cfg_reg.power_off_ms         <= POWOFF_RESET;
            cfg_reg.power_switch_present <= SWITCH_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WARMUP_MS:    cfg_reg.warmup_ms <= cfg_data[WARMUP_W-1:0];
                CFG_POWER_OFF_MS: cfg_reg.power_off_ms <= cfg_data[POWOFF_W-1:0];
                CFG_SWITCH:       cfg_reg.power_switch_present <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    pmwr_step u_step (
        .state_cur (state_reg),
        .cfg       (cfg_reg),
        .item      (in_data),
        .state_nxt (state_next),
        .result    (out_data_next)
    );

    // Controller state advances on every accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.clock_ms        <= '0;
            state_reg.warmup_start_ms <= '0;
            state_reg.recal_start_ms  <= '0;
            state_reg.recal_flag      <= 1'b0;
            state_reg.ready_flag      <= 1'b0;
            state_reg.previous_level  <= 1'b0;
            state_reg.motion_flag     <= 1'b0;
            state_reg.rise_count      <= '0;
            state_reg.event_kind      <= EV_NONE;
            state_reg.event_time_ms   <= '0;
            state_reg.power_flag      <= 1'b1;
        end else if (in_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register and its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== tb/pmwr_checker.sv =====
`timescale 1ns / 1ps

module pmwr_checker
    import pmwr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  pmwr_in_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  pmwr_out_t            out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   mismatch_total,
    output int                   ticks_in_flight
);

    // Shadow copy of the controller: settings, clocks, edge detector and event log.
    pmwr_cfg_t     settings;
    logic [31:0]   clock_ms;
    logic [31:0]   warmup_from;
    logic [31:0]   recal_from;
    logic [31:0]   event_at;
    logic [31:0]   rises;
    logic          recal_on;
    logic          warm_done;
    logic          level_seen;
    logic          motion_now;
    logic          powered;
    pmwr_event_t   event_kind;

    // Status beats predicted for ticks that have been taken but not yet answered.
    pmwr_out_t     due_status[$];

    // Advances the shadow controller by one millisecond tick and returns its status.
    task automatic advance_tick(input pmwr_in_t beat, output pmwr_out_t status);
        logic [31:0] now;
        logic [31:0] warm_elapsed;
        logic [31:0] warm_len;
        logic        granted;

        now      = clock_ms;
        warm_len = 32'(settings.warmup_ms);
        granted  = 1'b1;

        // The command acts before the sample of the same tick.
        if (beat.cmd == CMD_RECAL)
        begin
            if (!settings.power_switch_present)
                granted = 1'b0;
            else if (!recal_on)
            begin
                powered    = 1'b0;
                recal_on   = 1'b1;
                recal_from = now;
                warm_done  = 1'b0;
            end
        end
        else if (beat.cmd == CMD_CLEAR)
        begin
            rises = '0;
        end

        // While the supply is cut, samples are dropped; at the end of the cut the
        // supply comes back and warm-up starts over, dropping that tick's sample too.
        if (recal_on)
        begin
            if (now - recal_from >= 32'(settings.power_off_ms))
            begin
                powered     = 1'b1;
                warm_done   = 1'b0;
                warmup_from = now;
                motion_now  = 1'b0;
                level_seen  = 1'b0;
                recal_on    = 1'b0;
            end
        end
        else
        begin
            if (!warm_done && (now - warmup_from) >= warm_len)
                warm_done = 1'b1;
            if (beat.sensor_level && !level_seen)
            begin
                rises      = rises + 32'd1;
                event_at   = now;
                event_kind = EV_RISE;
            end
            if (!beat.sensor_level && level_seen)
            begin
                event_at   = now;
                event_kind = EV_FALL;
            end
            level_seen = beat.sensor_level;
            motion_now = beat.sensor_level;
        end

        status.motion        = motion_now;
        status.ready_res     = warm_done;
        status.recal_active  = recal_on;
        status.sensor_power  = powered;
        status.cmd_ok        = granted;
        status.event_count   = rises;
        status.last_event    = event_kind;
        status.last_event_ms = event_at;

        // Remaining warm-up time, counted even while the supply is cut.
        warm_elapsed = now - warmup_from;
        if (warm_done || warm_elapsed >= warm_len)
            status.warmup_left_ms = '0;
        else
            status.warmup_left_ms = WARMUP_W'(warm_len - warm_elapsed);

        clock_ms = now + 32'd1;
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            mismatch_total++;
        end
    endtask

    // Follow all three channels; settings and ticks update the shadow, results are checked.
    always @(posedge clk or negedge rst_n)
    begin
        pmwr_out_t fresh;
        pmwr_out_t oldest;

        if (!rst_n)
        begin
            settings.warmup_ms            = WARMUP_RESET;
            settings.power_off_ms         = POWOFF_RESET;
            settings.power_switch_present = SWITCH_RESET;
            clock_ms       = '0;
            warmup_from    = '0;
            recal_from     = '0;
            event_at       = '0;
            rises          = '0;
            recal_on       = 1'b0;
            warm_done      = 1'b0;
            level_seen     = 1'b0;
            motion_now     = 1'b0;
            powered        = 1'b1;
            event_kind     = EV_NONE;
            mismatch_total = 0;
            due_status.delete();
            ticks_in_flight <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WARMUP_MS:    settings.warmup_ms = cfg_data[WARMUP_W-1:0];
                    CFG_POWER_OFF_MS: settings.power_off_ms = cfg_data[POWOFF_W-1:0];
                    CFG_SWITCH:       settings.power_switch_present = cfg_data[0];
                    default:          ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                advance_tick(in_data, fresh);
                due_status.push_back(fresh);
            end

            if (out_valid && out_ready)
            begin
                if (due_status.size() == 0)
                begin
                    $display("%0t: status beat with no tick outstanding, expected none, actual %p",
                             $time, out_data);
                    mismatch_total++;
                end
                else
                begin
                    oldest = due_status.pop_front();
                    compare_field("motion", 32'(oldest.motion), 32'(out_data.motion));
                    compare_field("ready_res", 32'(oldest.ready_res), 32'(out_data.ready_res));
                    compare_field("recal_active", 32'(oldest.recal_active),
                                  32'(out_data.recal_active));
                    compare_field("sensor_power", 32'(oldest.sensor_power),
                                  32'(out_data.sensor_power));
                    compare_field("cmd_ok", 32'(oldest.cmd_ok), 32'(out_data.cmd_ok));
                    compare_field("event_count", oldest.event_count, out_data.event_count);
                    compare_field("last_event", 32'(oldest.last_event),
                                  32'(out_data.last_event));
                    compare_field("last_event_ms", oldest.last_event_ms,
                                  out_data.last_event_ms);
                    compare_field("warmup_left_ms", 32'(oldest.warmup_left_ms),
                                  32'(out_data.warmup_left_ms));
                end
            end

            ticks_in_flight <= due_status.size();
        end
    end

endmodule

// ===== tb/pir_motion_warmup_recal_controller_test.sv =====
`timescale 1ns / 1ps

module pir_motion_warmup_recal_controller_test;

    import pmwr_pkg::*;

    localparam int unsigned STALL_LIMIT     = 5000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned TICKS_PER_PHASE = 80;

    // Codes the package leaves unnamed: the spare register index and command.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [1:0]           CMD_SPARE = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_CHOKE
    } rx_mode_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    pmwr_in_t             in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 in_ready;
    logic                 out_valid;
    pmwr_out_t            out_data;
    logic                 cfg_ready;
    int                   mismatch_total;
    int                   ticks_in_flight;

    int unsigned          burst_left      = 0;
    int unsigned          quiet_cycles    = 0;
    rx_mode_t             rx_mode         = RX_OPEN;
    int unsigned          rx_mode_left    = 0;

    pir_motion_warmup_recal_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pmwr_checker status_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_total  (mismatch_total),
        .ticks_in_flight (ticks_in_flight)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The result side switches between always ready, coin-flip and mostly stalled.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      <= rx_mode_t'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(16, 96);
        end
        else
        begin
            rx_mode_left <= rx_mode_left - 1;
        end

        case (rx_mode)
            RX_OPEN:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
            default:  out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Ends the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("pir_motion_warmup_recal_controller_test: FAIL");
                $finish;
            end
        end
    end

    // Offers one tick, in bursts with random gaps between them.
    task automatic send_tick(input logic [1:0] cmd, input logic level);
        pmwr_in_t    beat;
        int unsigned gap;

        beat.cmd          = cmd;
        beat.sensor_level = level;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(30, 80);
            else
                burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    // Stops offering ticks and waits until every status beat has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ticks_in_flight != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Rewrites every register once the controller is idle; unused upper bits may be set.
    task automatic apply_settings(input logic [CFG_DAT_W-1:0] warm_word,
                                  input logic [CFG_DAT_W-1:0] off_word,
                                  input logic [CFG_DAT_W-1:0] switch_word);
        settle();
        write_reg(CFG_SPARE, CFG_DAT_W'($urandom_range(0, 1048575)));
        write_reg(CFG_WARMUP_MS, warm_word);
        write_reg(CFG_POWER_OFF_MS, off_word);
        write_reg(CFG_SWITCH, switch_word);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic        level_now;
        logic [1:0]  cmd;
        int unsigned pick;
        int unsigned warm_val;
        int unsigned off_val;
        logic        switch_val;

        level_now = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, no switch: edges, count clears and a refused recalibration.
        send_tick(CMD_TICK, 1'b0);
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_CLEAR, 1'b1);
        send_tick(CMD_TICK, 1'b0);
        send_tick(CMD_CLEAR, 1'b1);
        send_tick(CMD_RECAL, 1'b1);
        send_tick(CMD_SPARE, 1'b0);

        // No warm-up and a zero-length cut: the recalibration ends in its own tick.
        apply_settings(20'd0, 20'd0, 20'd1);
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_RECAL, 1'b1);
        send_tick(CMD_TICK, 1'b1);

        // Longest warm-up and cut; samples and repeated requests during the cut.
        apply_settings(20'hFFFFF, 20'h0FFFF, 20'h00001);
        send_tick(CMD_TICK, 1'b0);
        send_tick(CMD_RECAL, 1'b1);
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_RECAL, 1'b0);
        send_tick(CMD_CLEAR, 1'b1);

        // Switch removed mid-cut: the request is refused, yet the supply still comes back.
        apply_settings(20'hFFFFF, 20'h0FFFF, 20'hFFFFE);
        send_tick(CMD_RECAL, 1'b1);
        apply_settings(20'hFFFFF, 20'hF0002, 20'hFFFFE);
        send_tick(CMD_TICK, 1'b1);
        send_tick(CMD_TICK, 1'b1);

        // Short warm-up that runs out within a few ticks.
        apply_settings(20'd3, 20'd5, 20'd1);
        send_tick(CMD_TICK, 1'b0);
        send_tick(CMD_TICK, 1'b0);
        send_tick(CMD_TICK, 1'b1);

        // Random phases: mostly short warm-ups and cuts so every state is visited often.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                warm_val   = 0;
                off_val    = 1;
                switch_val = 1'b1;
            end
            else if (phase == RANDOM_PHASES - 1)
            begin
                warm_val   = 1048575;
                off_val    = $urandom_range(1, 6);
                switch_val = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    warm_val = $urandom_range(0, 1048575);
                else
                    warm_val = $urandom_range(0, 40);
                if ($urandom_range(0, 15) == 0)
                    off_val = $urandom_range(1, 65535);
                else
                    off_val = $urandom_range(1, 10);
                switch_val = ($urandom_range(0, 4) != 0);
            end
            apply_settings(CFG_DAT_W'(warm_val),
                           {4'($urandom_range(0, 15)), 16'(off_val)},
                           {19'($urandom_range(0, 524287)), switch_val});

            repeat (TICKS_PER_PHASE)
            begin
                // The level holds for a few ticks so edges come in realistic runs.
                if ($urandom_range(0, 2) == 0)
                    level_now = ~level_now;
                pick = $urandom_range(0, 99);
                if (pick < 78)
                    cmd = CMD_TICK;
                else if (pick < 88)
                    cmd = CMD_RECAL;
                else if (pick < 96)
                    cmd = CMD_CLEAR;
                else
                    cmd = CMD_SPARE;
                send_tick(cmd, level_now);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_total == 0)
            $display("pir_motion_warmup_recal_controller_test: PASS");
        else
            $display("pir_motion_warmup_recal_controller_test: FAIL");
        $finish;
    end

endmodule
